### design/cpc_pkg.sv
`default_nettype none

package cpc_pkg;

  localparam int unsigned PixelWidth   = 32;
  localparam int unsigned ChanWidth    = 8;
  localparam int unsigned ProdWidth    = 2 * ChanWidth;
  localparam int unsigned NumChans     = 3;
  localparam int unsigned ModeWidth    = 2;

  localparam logic [ModeWidth-1:0] MODE_ALPHA  = 2'd0;
  localparam logic [ModeWidth-1:0] MODE_MASKED = 2'd1;

  localparam logic [PixelWidth-1:0] ALPHA_MASK   = 32'hFF00_0000;
  localparam logic [PixelWidth-1:0] COLOR_MASK   = 32'h00FF_FFFF;
  localparam logic [PixelWidth-1:0] OPAQUE_WHITE = 32'hFFFF_FFFF;
  localparam logic [PixelWidth-1:0] OPAQUE_BLACK = 32'hFF00_0000;
  localparam logic [PixelWidth-1:0] TRANSPARENT  = 32'h0000_0000;
  localparam logic [ChanWidth-1:0]  FULL_SCALE   = 8'hFF;

  // Entry stage: either a finished pixel, or a pixel whose colour channels still
  // need scaling by alpha.
  typedef struct packed {
    logic                  valid;
    logic                  scale;
    logic [PixelWidth-1:0] pix;
  } entry_t;

  // After the multipliers: products of each colour channel with alpha.
  typedef struct packed {
    logic                                valid;
    logic                                scale;
    logic [ChanWidth-1:0]                alpha;
    logic [NumChans-1:0][ProdWidth-1:0]  prod;
    logic [PixelWidth-1:0]               pix;
  } prod_t;

  // floor(p / 255) for p up to 255*255, without a divider.
  function automatic logic [ChanWidth-1:0] div255(input logic [ProdWidth-1:0] p);
    logic [ProdWidth:0] s;
    s = {1'b0, p} + {{ProdWidth{1'b0}}, 1'b1}
        + {{(ChanWidth+1){1'b0}}, p[ProdWidth-1:ChanWidth]};
    return s[ProdWidth-1:ChanWidth];
  endfunction

endpackage

`default_nettype wire

### design/cursor_pixel_converter_core.sv
`default_nettype none
// Channel    Direction  Signals                                    Handshake
// request    in         color_pixel_i, and_bit_i, xor_bit_i        start_i while busy_o is low
// result     out        pixel_out_o                                done_o, one cycle
// config     in         cfg_wdata_i (pixel_mode)                   cfg_we_i
//
// A pixel request is taken on every clock edge at which start_i is high; busy_o
// is held low because the pipeline never fills up. Each result passes through
// the entry, multiplier and divide-by-255 register stages, and results come
// out one per cycle at full rate. The receiver cannot stall, so nothing is held
// back. Reset clears the valid bits and sets the mode to alpha.

module cursor_pixel_converter_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic [cpc_pkg::PixelWidth-1:0]      color_pixel_i,
  input  wire logic                                and_bit_i,
  input  wire logic                                xor_bit_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [cpc_pkg::ModeWidth-1:0]       cfg_wdata_i,
  output logic                                     done_o,
  output logic [cpc_pkg::PixelWidth-1:0]           pixel_out_o
);
  import cpc_pkg::*;

  logic [ModeWidth-1:0]  mode_q;
  logic                  valid_q;
  logic                  scale_q;
  logic                  scale_d;
  logic [PixelWidth-1:0] pix_q;
  logic [PixelWidth-1:0] pix_d;
  entry_t                entry;
  prod_t                 prod;

  // The mode register must be rewritten only while the pipeline is empty; nothing checks it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ALPHA;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // Every case except a partial alpha is settled here, so the later stages only
  // scale or pass the pixel through.
  always_comb begin
    scale_d = 1'b0;
    pix_d   = color_pixel_i;
    case (mode_q)
      MODE_ALPHA: begin
        if (color_pixel_i[PixelWidth-1 -: ChanWidth] == FULL_SCALE) begin
          pix_d = color_pixel_i;
        end else if (color_pixel_i[PixelWidth-1 -: ChanWidth] == '0) begin
          pix_d = TRANSPARENT;
        end else begin
          scale_d = 1'b1;
        end
      end
      MODE_MASKED: begin
        pix_d = and_bit_i ? TRANSPARENT : ((color_pixel_i & COLOR_MASK) | ALPHA_MASK);
      end
      default: begin
        // Monochrome; the unassigned code behaves the same way.
        if (xor_bit_i) begin
          pix_d = OPAQUE_WHITE;
        end else if (and_bit_i) begin
          pix_d = TRANSPARENT;
        end else begin
          pix_d = OPAQUE_BLACK;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    scale_q <= scale_d;
    pix_q   <= pix_d;
  end

  assign entry.valid = valid_q;
  assign entry.scale = scale_q;
  assign entry.pix   = pix_q;

  cpc_mul_stage u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .entry_i (entry),
    .prod_o  (prod)
  );

  cpc_div_stage u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .prod_i  (prod),
    .valid_o (done_o),
    .pixel_o (pixel_out_o)
  );

  assign busy_o = 1'b0;

endmodule

`default_nettype wire

### design/cpc_mul_stage.sv
`default_nettype none

module cpc_mul_stage (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cpc_pkg::entry_t entry_i,
  output cpc_pkg::prod_t       prod_o
);
  import cpc_pkg::*;

  logic                               valid_q;
  logic                               scale_q;
  logic [ChanWidth-1:0]               alpha_q;
  logic [NumChans-1:0][ProdWidth-1:0] prod_q;
  logic [NumChans-1:0][ProdWidth-1:0] prod_d;
  logic [PixelWidth-1:0]              pix_q;

  always_comb begin
    for (int c = 0; c < NumChans; c++) begin
      prod_d[c] = ProdWidth'(entry_i.pix[c*ChanWidth +: ChanWidth])
                  * ProdWidth'(entry_i.pix[PixelWidth-1 -: ChanWidth]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= entry_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    scale_q <= entry_i.scale;
    alpha_q <= entry_i.pix[PixelWidth-1 -: ChanWidth];
    prod_q  <= prod_d;
    pix_q   <= entry_i.pix;
  end

  assign prod_o.valid = valid_q;
  assign prod_o.scale = scale_q;
  assign prod_o.alpha = alpha_q;
  assign prod_o.prod  = prod_q;
  assign prod_o.pix   = pix_q;

endmodule

`default_nettype wire

### design/cpc_div_stage.sv
`default_nettype none

module cpc_div_stage (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire cpc_pkg::prod_t              prod_i,
  output logic                             valid_o,
  output logic [cpc_pkg::PixelWidth-1:0]   pixel_o
);
  import cpc_pkg::*;

  logic                  valid_q;
  logic [PixelWidth-1:0] pixel_q;
  logic [PixelWidth-1:0] pixel_d;

  always_comb begin
    if (prod_i.scale) begin
      pixel_d = {prod_i.alpha, div255(prod_i.prod[2]), div255(prod_i.prod[1]),
                 div255(prod_i.prod[0])};
    end else begin
      pixel_d = prod_i.pix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= prod_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pixel_q <= pixel_d;
  end

  assign valid_o = valid_q;
  assign pixel_o = pixel_q;

endmodule

`default_nettype wire

### bench/cursor_pixel_converter_core_tb.sv
module cursor_pixel_converter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cpc_pkg::*;

  // The package names only the alpha and masked codes. Monochrome is code 2.
  // Code 3 is unassigned: it falls to the default branch of the mode decode,
  // so it must behave exactly as monochrome does.
  localparam logic [ModeWidth-1:0] MODE_MONO  = 2'd2;
  localparam logic [ModeWidth-1:0] MODE_SPARE = 2'd3;

  // Reporting and watchdog limits, the final drain, and the size of the random part.
  localparam int unsigned ReportLimit   = 10;
  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned ItemsPerPhase = 75;

  // Holds the converted pixels that are still owed by the block, in request
  // order, together with its own copy of the mode register.
  class pixel_scoreboard;
    logic [ModeWidth-1:0]  mode;
    logic [PixelWidth-1:0] expected_pixels[$];
    int unsigned           mismatches;

    function new();
      mode       = MODE_ALPHA;
      mismatches = 0;
    endfunction

    function void set_mode(input logic [ModeWidth-1:0] m);
      mode = m;
    endfunction

    // Scales the three colour channels by alpha, rounding down.
    function logic [PixelWidth-1:0] premultiply(input logic [PixelWidth-1:0] pix);
      logic [ChanWidth-1:0]  alpha;
      logic [PixelWidth-1:0] res;
      int unsigned           prod;
      alpha = pix[31:24];
      if (alpha == FULL_SCALE) return pix;
      if (alpha == 8'h00) return TRANSPARENT;
      res = {alpha, 24'h0};
      for (int c = 0; c < NumChans; c++) begin
        prod = int'(pix[c*ChanWidth +: ChanWidth]) * int'(alpha);
        res[c*ChanWidth +: ChanWidth] = ChanWidth'(prod / 255);
      end
      return res;
    endfunction

    function logic [PixelWidth-1:0] convert(input logic [PixelWidth-1:0] pix,
                                            input logic and_b, input logic xor_b);
      case (mode)
        MODE_ALPHA:  return premultiply(pix);
        MODE_MASKED: return and_b ? TRANSPARENT : ((pix & COLOR_MASK) | ALPHA_MASK);
        default: begin
          if (xor_b) return OPAQUE_WHITE;
          if (and_b) return TRANSPARENT;
          return OPAQUE_BLACK;
        end
      endcase
    endfunction

    function void note_request(input logic [PixelWidth-1:0] pix,
                               input logic and_b, input logic xor_b);
      expected_pixels.push_back(convert(pix, and_b, xor_b));
    endfunction

    function void check_result(input logic [PixelWidth-1:0] actual);
      logic [PixelWidth-1:0] want;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("unexpected result %08h at %0t", actual, $time);
        return;
      end
      want = expected_pixels.pop_front();
      if (actual !== want) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("pixel mismatch at %0t: expected %08h, got %08h",
                   $time, want, actual);
      end
    endfunction

    function int unsigned pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic [PixelWidth-1:0] color_pixel_i;
  logic                  and_bit_i;
  logic                  xor_bit_i;
  logic                  cfg_we_i;
  logic [ModeWidth-1:0]  cfg_wdata_i;
  logic                  done_o;
  logic [PixelWidth-1:0] pixel_out_o;

  pixel_scoreboard sb = new();
  int unsigned     quiet_cycles;

  cursor_pixel_converter_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .color_pixel_i (color_pixel_i),
    .and_bit_i     (and_bit_i),
    .xor_bit_i     (xor_bit_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .pixel_out_o   (pixel_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Monitor. Everything is sampled at the rising edge, before the block's own
  // registers change, so each sample is the value of the cycle that the edge
  // ends. A request is taken when start is high and busy is low; a result is
  // taken whenever the strobe is high, as the receiver has no way to refuse it.
  // The watchdog counts edges at which neither a request nor a result moves.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) sb.note_request(color_pixel_i, and_bit_i, xor_bit_i);
      if (done_o) sb.check_result(pixel_out_o);
      if ((start_i && !busy_o) || done_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
        $display("watchdog expired at %0t", $time);
        $display("cursor_pixel_converter_core_tb NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offers one request and returns at the edge that takes it. Before the
  // request the sender may sit idle for a random number of cycles; the chance
  // of idling in any one cycle is idle_pct in a hundred. When no idle cycle is
  // drawn, start stays high from the previous request so that back-to-back
  // requests are seen at full rate.
  task automatic send_pixel(input logic [PixelWidth-1:0] pix, input logic and_b,
                            input logic xor_b, input int unsigned idle_pct);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start_i       <= 1'b1;
    color_pixel_i <= pix;
    and_bit_i     <= and_b;
    xor_bit_i     <= xor_b;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Lowers start and waits until every result that is owed has come back.
  // It first waits for a clock edge, so that the monitor has certainly noted the last
  // request before the store is looked at. Each request gives exactly one
  // result, so an empty store then means the pipeline holds nothing and the
  // mode may safely be changed.
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Writes the mode register while the block is idle, and updates the
  // prediction at the same edge at which the block takes the write.
  task automatic write_mode(input logic [ModeWidth-1:0] m);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_mode(m);
  endtask

  // Random pixel, now and then pushed towards the alpha and colour extremes
  // that select the special paths of the premultiplier.
  function automatic logic [PixelWidth-1:0] random_pixel();
    logic [PixelWidth-1:0] pix;
    int unsigned           pick;
    pix  = $urandom;
    pick = $urandom_range(15);
    case (pick)
      0: pix[31:24] = 8'h00;
      1: pix[31:24] = 8'hFF;
      2: pix[31:24] = 8'h01;
      3: pix[31:24] = 8'hFE;
      4: pix[23:0]  = 24'hFF_FFFF;
      5: pix[23:0]  = 24'h00_0000;
      default: ;
    endcase
    return pix;
  endfunction

  logic [ModeWidth-1:0] phase_mode [NumPhases] = '{MODE_ALPHA, MODE_MASKED, MODE_MONO,
                                                   MODE_SPARE, MODE_MONO, MODE_ALPHA,
                                                   MODE_MASKED, MODE_ALPHA};
  int unsigned          phase_idle [NumPhases] = '{0, 61, 30, 0, 61, 30, 61, 0};

  initial begin
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    color_pixel_i = '0;
    and_bit_i     = 1'b0;
    xor_bit_i     = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    quiet_cycles  = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, first in the alpha mode that reset leaves behind: full
    // alpha passes through untouched, zero alpha clears the whole pixel, and
    // the in-between alphas exercise the floor of the division at both ends.
    send_pixel(32'hFFFF_FFFF, 1'b1, 1'b1, 0);
    send_pixel(32'hFF12_3456, 1'b0, 1'b0, 0);
    send_pixel(32'h00FF_FFFF, 1'b1, 1'b0, 0);
    send_pixel(32'h0000_0000, 1'b0, 1'b1, 0);
    send_pixel(32'h01FF_FFFF, 1'b0, 1'b0, 0);
    send_pixel(32'hFEFF_FFFF, 1'b0, 1'b0, 0);
    send_pixel(32'h8001_7F80, 1'b0, 1'b0, 0);
    send_pixel(32'h7FFE_0180, 1'b1, 1'b1, 0);
    drain();

    // Colour with AND mask: a set AND bit gives transparent zero whatever the
    // colour, a clear one forces alpha to opaque; the XOR bit has no say.
    write_mode(MODE_MASKED);
    send_pixel(32'hFFFF_FFFF, 1'b1, 1'b0, 0);
    send_pixel(32'h00AB_CDEF, 1'b0, 1'b0, 0);
    send_pixel(32'h0000_0000, 1'b0, 1'b1, 0);
    send_pixel(32'h5AFF_FFFF, 1'b1, 1'b1, 0);
    drain();

    // Monochrome: every combination of the two mask bits, with the colour
    // input set to values that must be ignored.
    write_mode(MODE_MONO);
    send_pixel(32'hFFFF_FFFF, 1'b0, 1'b0, 0);
    send_pixel(32'h0000_0000, 1'b1, 1'b0, 0);
    send_pixel(32'h1234_5678, 1'b0, 1'b1, 0);
    send_pixel(32'hFFFF_FFFF, 1'b1, 1'b1, 0);
    drain();

    // The unassigned mode must decode as monochrome.
    write_mode(MODE_SPARE);
    send_pixel(32'hFFFF_FFFF, 1'b0, 1'b0, 0);
    send_pixel(32'h0000_0000, 1'b1, 1'b0, 0);
    send_pixel(32'hDEAD_BEEF, 1'b0, 1'b1, 0);
    send_pixel(32'h8000_0001, 1'b1, 1'b1, 0);
    drain();

    // Random part: each phase picks a mode and an idling profile for the
    // sender, and streams random pixels with random mask bits.
    for (int p = 0; p < NumPhases; p++) begin
      write_mode(phase_mode[p]);
      for (int n = 0; n < ItemsPerPhase; n++)
        send_pixel(random_pixel(), 1'($urandom), 1'($urandom), phase_idle[p]);
      drain();
    end

    // Allow for any stray result that might still follow the last one.
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("cursor_pixel_converter_core_tb OK");
    end else begin
      $display("cursor_pixel_converter_core_tb NOT OK");
    end
    $finish;
  end

endmodule

### cursor_pixel_converter_core.f
design/cpc_pkg.sv
design/cpc_mul_stage.sv
design/cpc_div_stage.sv
design/cursor_pixel_converter_core.sv
bench/cursor_pixel_converter_core_tb.sv
